>>> sv/base85_encoder_macros.svh
// Assertion helpers used by the checker module b85_check.
`ifndef BASE85_ENCODER_MACROS_SVH
`define BASE85_ENCODER_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define B85_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define B85_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/b85_pkg.sv
package b85_pkg;

   // Digits in one full group and queue sizing
   localparam int GRP_DIGITS  = 5;
   localparam int DIGIT_IDX_W = $clog2(GRP_DIGITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // x / 85 == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
   localparam int          RECIP_SHIFT = 38;
   localparam int          QUOT_W      = 64 - RECIP_SHIFT;

   // ASCII bases of the alphabet ranges
   localparam logic [6:0] CHR_DIGIT_BASE = 7'd48;
   localparam logic [6:0] CHR_UPPER_OFFS = 7'd55;
   localparam logic [6:0] CHR_LOWER_OFFS = 7'd61;
   localparam logic [6:0] CHR_PUNCT_IDX  = 7'd62;
   localparam logic [6:0] CHR_LAST       = 7'd126;

   // Punctuation tail of the alphabet: !#$%&()*+-;<=>?@^_`{|}~
   localparam logic [6:0] PUNCT_CHARS [23] = '{
      7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42,
      7'd43, 7'd45, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64,
      7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126
   };

   // One closed group waiting for conversion
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  ndig;
      logic        fin;
   } job_type;

   // One converted group, digit 0 is the most significant
   typedef struct packed {
      logic [GRP_DIGITS-1:0][6:0] digits;
      logic [2:0]                 ndig;
      logic                       fin;
   } grp_type;

   // Map a digit value to its alphabet character
   function automatic logic [6:0] b85_char(input logic [6:0] d);
      logic [6:0] c;
      if (d < 7'd10) begin
         c = CHR_DIGIT_BASE + d;
      end else if (d < 7'd36) begin
         c = CHR_UPPER_OFFS + d;
      end else if (d < 7'd62) begin
         c = CHR_LOWER_OFFS + d;
      end else if (d < 7'd85) begin
         c = PUNCT_CHARS[5'(d - CHR_PUNCT_IDX)];
      end else begin
         c = CHR_LAST;
      end
      return c;
   endfunction

endpackage

>>> sv/b85_front.sv
module b85_front
   import b85_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   logic [23:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closes;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign closes    = (count_ff == 2'd3) || req_final_byte;
   assign q_push    = accept && closes;

   // Build the zero-padded group word and its digit count
   always_comb begin
      case (count_ff)
         2'd0:    q_job.value = {req_data_byte, 24'h0};
         2'd1:    q_job.value = {held_ff[7:0], req_data_byte, 16'h0};
         2'd2:    q_job.value = {held_ff[15:0], req_data_byte, 8'h0};
         default: q_job.value = {held_ff, req_data_byte};
      endcase
      q_job.ndig = {1'b0, count_ff} + 3'd2;
      q_job.fin  = req_final_byte;
   end

   // Hold open bytes, drop them once the group closes
   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      if (accept) begin
         if (closes) begin
            held_in  = '0;
            count_in = '0;
         end else begin
            held_in  = {held_ff[15:0], req_data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         count_ff <= '0;
      end else begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/b85_queue.sv
module b85_queue
   import b85_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/b85_conv.sv
module b85_conv
   import b85_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   output logic    grp_valid,
   output grp_type grp,
   input  logic    grp_ready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [31:0]             x_ff;
   logic [2:0]              step_ff;
   grp_type                 grp_ff;
   logic [63:0]             prod;
   logic [QUOT_W-1:0]       quot;
   logic [6:0]              q85_lo;
   logic [6:0]              digit;
   logic [DIGIT_IDX_W-1:0]  digit_idx;

   // Divide the remainder by 85: quotient by reciprocal, digit from the low bits
   assign prod      = 64'(x_ff) * 64'(RECIP_85);
   assign quot      = prod[63:RECIP_SHIFT];
   assign q85_lo    = 7'({quot, 6'b0}) + 7'({quot, 4'b0}) + 7'({quot, 2'b0}) + 7'(quot);
   assign digit     = x_ff[6:0] - q85_lo;
   assign digit_idx = DIGIT_IDX_W'(GRP_DIGITS - 1) - DIGIT_IDX_W'(step_ff);

   assign q_pop     = !q_empty && ((state_ff == ST_IDLE) ||
                                   ((state_ff == ST_DONE) && grp_ready));
   assign grp_valid = (state_ff == ST_DONE);
   assign grp       = grp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  x_ff        <= q_job.value;
                  grp_ff.ndig <= q_job.ndig;
                  grp_ff.fin  <= q_job.fin;
                  step_ff     <= '0;
                  state_ff    <= ST_RUN;
               end
            end
            ST_RUN: begin
               // Peel one digit per cycle, least significant first
               grp_ff.digits[digit_idx] <= digit;
               x_ff    <= 32'(quot);
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'(GRP_DIGITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (grp_ready) begin
                  if (q_pop) begin
                     x_ff        <= q_job.value;
                     grp_ff.ndig <= q_job.ndig;
                     grp_ff.fin  <= q_job.fin;
                     step_ff     <= '0;
                     state_ff    <= ST_RUN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/b85_emit.sv
module b85_emit
   import b85_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       grp_valid,
   input  grp_type    grp,
   output logic       grp_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_group_end,
   output logic       rsp_message_end
);

   grp_type                slot_ff;
   logic                   slot_valid_ff, slot_valid_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [6:0]             char_ff;
   logic                   group_end_ff;
   logic                   message_end_ff;
   logic                   advance;
   logic                   emit;
   logic                   last;
   logic                   load;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = slot_valid_ff && advance;
   assign last      = (idx_ff == (slot_ff.ndig - 3'd1));
   assign grp_ready = !slot_valid_ff || (emit && last);
   assign load      = grp_valid && grp_ready;

   // Walk the slot one character per word, free it on the last one
   always_comb begin
      slot_valid_in = load || (slot_valid_ff && !(emit && last));
      idx_in        = idx_ff;
      if (emit) begin
         idx_in = last ? '0 : idx_ff + DIGIT_IDX_W'(1);
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture group and output word payloads
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= grp;
      end
      if (emit) begin
         char_ff        <= b85_char(slot_ff.digits[idx_ff]);
         group_end_ff   <= last;
         message_end_ff <= last && slot_ff.fin;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_group_end   = group_end_ff;
   assign rsp_message_end = message_end_ff;

endmodule

>>> sv/base85_encoder.sv
// Base-85 encoder, one message byte in per word, one alphabet character out per word.
// Input channel req_*: data byte plus a flag on the last byte of a message.
// Output channel rsp_*: ASCII character, group_end on the last character a byte
// causes, message_end on the final character of the message.
// Bytes are packed big-endian in groups of four; a full group gives five characters,
// a final partial group of n bytes gives n+1 characters.
// The first character of a group shows on rsp_* once the byte that closes it has
// passed the group queue, the converter's digit steps, the output slot and the output
// register; the others follow one per cycle while rsp_stall is low. The converter
// turns out one digit per cycle and works on one group at a time; the characters
// of a group go out one word per cycle unless rsp_stall holds them. Bytes that do not
// close a group are taken every cycle without output while req_stall is low.
// Stall on rsp holds the output word; the converter then waits, a two-entry group
// queue fills, and req_stall rises until space frees.
// Reset empties the held bytes, the queue, the converter and the output register.
module base85_encoder
   import b85_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_group_end,
   output logic       rsp_message_end
);

   job_type push_job;
   job_type pop_job;
   grp_type grp;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   logic    grp_valid;
   logic    grp_ready;

   b85_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   b85_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   b85_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .grp_valid (grp_valid),
      .grp       (grp),
      .grp_ready (grp_ready)
   );

   b85_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .grp_valid       (grp_valid),
      .grp             (grp),
      .grp_ready       (grp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_group_end   (rsp_group_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

>>> sv/b85_check.sv
`include "base85_encoder_macros.svh"

module b85_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_out_char,
   input logic       rsp_group_end,
   input logic       rsp_message_end
);

   // Characters stay inside the printable alphabet range
   `B85_ASSERT_NOW(a_char_range, rsp_valid, (rsp_out_char >= 7'd33) && (rsp_out_char <= 7'd126), "character outside alphabet range")

   // The final character of a message also closes its group
   `B85_ASSERT_NOW(a_msg_in_group, rsp_valid && rsp_message_end, rsp_group_end, "message end without group end")

   // Characters of one group follow without a gap
   `B85_ASSERT_NEXT(a_group_burst, rsp_valid && !rsp_stall && !rsp_group_end, rsp_valid, "gap inside a group")

   // A stalled output word holds
   `B85_ASSERT_NEXT(a_hold_stalled, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_char) && $stable(rsp_group_end) && $stable(rsp_message_end), "stalled output word changed")

endmodule

bind base85_encoder b85_check u_check (.*);
